// ----- design/lzsw_pkg.sv -----
// Shared types and constants for the LZSS window decompressor.
package lzsw_pkg;

	localparam int unsigned WIN_AW    = 12;
	localparam int unsigned WIN_DEPTH = 1 << WIN_AW;
	localparam logic [WIN_AW-1:0] WIN_START = 12'hFEE;
	localparam logic [WIN_AW-1:0] WIN_LAST  = 12'hFFF;
	localparam logic [4:0] MIN_MATCH = 5'd3;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LIT,
		ST_COPY
	} state_t;

	typedef enum logic [2:0] {
		PH_HDR0  = 3'd0,
		PH_HDR1  = 3'd1,
		PH_HDR2  = 3'd2,
		PH_HDR3  = 3'd3,
		PH_ITEM  = 3'd4,
		PH_MATCH = 3'd5,
		PH_DONE  = 3'd6
	} phase_t;

	typedef struct packed {
		logic              we;
		logic [WIN_AW-1:0] waddr;
		logic [7:0]        wdata;
		logic              re;
		logic [WIN_AW-1:0] raddr;
	} ram_req_t;

	typedef struct packed {
		logic       load;
		logic [7:0] data;
		logic       run_last;
		logic       stream_last;
	} out_word_t;

endpackage

// ----- design/lzss_window_decompressor_top.sv -----
// Top level of the LZSS decompressor with a 4096-byte history window.
//
// channel  dir  tdata              tuser         tlast
// s_*      in   [7:0] in_byte      start_req     -
// m_*      out  [7:0] out_byte     stream_last   run_last
//
// A literal is accepted, then written to the window and loaded to the output.
// A second match byte (len 3 to 18) is accepted, then the window RAM is read
// through its registered read port, then one byte per cycle is copied while
// the output is free. After reset and after any word with start_req the
// window is cleared one entry per cycle with s_tready low. A full output
// register holds a literal or copy in place; one finished word may wait there.
module lzss_window_decompressor_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tuser,   // [0] start_req
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tuser,   // [0] stream_last
	output logic       m_tlast
);

	lzsw_pkg::ram_req_t  ram_req;
	lzsw_pkg::out_word_t ob;
	logic [7:0]          rd_data;
	logic                out_free;

	logic       m_tvalid_q;
	logic [7:0] m_tdata_q;
	logic       m_tlast_q;
	logic       m_tuser_q;

	// output slot is free when empty or being drained this cycle
	assign out_free = !m_tvalid_q || m_tready;

	lzsw_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.in_start (s_tuser),
		.out_free (out_free),
		.rd_data  (rd_data),
		.ram_req  (ram_req),
		.ob       (ob)
	);

	lzsw_window_ram u_ram (
		.clk     (clk),
		.req     (ram_req),
		.rd_data (rd_data)
	);

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ob.load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ob.load) begin
			m_tdata_q <= ob.data;
			m_tlast_q <= ob.run_last;
			m_tuser_q <= ob.stream_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

	// end of stream always closes the run of its input word
	a_stream_last_has_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("stream_last without run_last");

	// a start request starts the window clear pass
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser |=> !s_tready)
		else $error("no clear pass after start request");

	// the sequencer never overwrites a word still waiting at the output
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ob.load |-> out_free)
		else $error("output word overwritten");

endmodule

// ----- design/lzsw_window_ram.sv -----
// 4096 x 8 history window, one write port and one registered read port.
module lzsw_window_ram (
	input  logic                clk,
	input  lzsw_pkg::ram_req_t  req,
	output logic [7:0]          rd_data
);

	logic [7:0] mem_q [lzsw_pkg::WIN_DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_data_q <= mem_q[req.raddr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- design/lzsw_seq.sv -----
// Sequencer: header, flag and match parsing, window clear and copy loop.
module lzsw_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           in_byte,
	input  logic                 in_start,
	input  logic                 out_free,
	input  logic [7:0]           rd_data,
	output lzsw_pkg::ram_req_t   ram_req,
	output lzsw_pkg::out_word_t  ob
);

	lzsw_pkg::state_t state_q, state_d;
	lzsw_pkg::phase_t phase_q, phase_d;

	logic [31:0]               rem_q, rem_d, rem_dec;
	logic [8:0]                flag_q, flag_d;
	logic [7:0]                mlow_q, mlow_d;
	logic [lzsw_pkg::WIN_AW-1:0] wp_q, wp_d;
	logic [lzsw_pkg::WIN_AW-1:0] clr_q, clr_d;
	logic [7:0]                lit_q, lit_d;
	logic [lzsw_pkg::WIN_AW-1:0] rd_ptr_q, rd_ptr_d;
	logic [4:0]                rd_left_q, rd_left_d;
	logic [4:0]                em_left_q, em_left_d;
	logic                      dv_q, dv_d;
	logic                      byp_q, byp_d;
	logic [7:0]                byp_data_q, byp_data_d;

	logic       put_en;
	logic [7:0] put_byte;
	logic       put_run_last;
	logic       fin;
	logic [7:0] copy_byte;

	assign rem_dec   = rem_q - 32'd1;
	assign fin       = (rem_dec == 32'd0);
	// a read that hit the address written in the same cycle sees the new byte
	assign copy_byte = byp_q ? byp_data_q : rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lzsw_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= lzsw_pkg::PH_HDR0;
			rem_q     <= '0;
			flag_q    <= '0;
			mlow_q    <= '0;
			wp_q      <= lzsw_pkg::WIN_START;
			clr_q     <= '0;
			rd_left_q <= '0;
			em_left_q <= '0;
			dv_q      <= 1'b0;
			byp_q     <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			rem_q     <= rem_d;
			flag_q    <= flag_d;
			mlow_q    <= mlow_d;
			wp_q      <= wp_d;
			clr_q     <= clr_d;
			rd_left_q <= rd_left_d;
			em_left_q <= em_left_d;
			dv_q      <= dv_d;
			byp_q     <= byp_d;
		end
	end

	always_ff @(posedge clk) begin
		lit_q      <= lit_d;
		rd_ptr_q   <= rd_ptr_d;
		byp_data_q <= byp_data_d;
	end

	always_comb begin
		state_d      = state_q;
		phase_d      = phase_q;
		rem_d        = rem_q;
		flag_d       = flag_q;
		mlow_d       = mlow_q;
		wp_d         = wp_q;
		clr_d        = clr_q;
		lit_d        = lit_q;
		rd_ptr_d     = rd_ptr_q;
		rd_left_d    = rd_left_q;
		em_left_d    = em_left_q;
		dv_d         = dv_q;
		byp_d        = byp_q;
		byp_data_d   = byp_data_q;
		ram_req      = '0;
		ob           = '0;
		put_en       = 1'b0;
		put_byte     = lit_q;
		put_run_last = 1'b1;
		in_ready     = (state_q == lzsw_pkg::ST_IDLE);

		case (state_q)
			lzsw_pkg::ST_CLEAR: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = clr_q;
				ram_req.wdata = 8'h00;
				clr_d         = clr_q + 1'b1;
				if (clr_q == lzsw_pkg::WIN_LAST) begin
					state_d = lzsw_pkg::ST_IDLE;
				end
			end
			lzsw_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (in_start) begin
						rem_d   = {24'd0, in_byte};
						phase_d = lzsw_pkg::PH_HDR1;
						wp_d    = lzsw_pkg::WIN_START;
						flag_d  = '0;
						mlow_d  = '0;
						clr_d   = '0;
						state_d = lzsw_pkg::ST_CLEAR;
					end else begin
						case (phase_q)
							lzsw_pkg::PH_HDR0: begin
								rem_d   = {24'd0, in_byte};
								phase_d = lzsw_pkg::PH_HDR1;
							end
							lzsw_pkg::PH_HDR1: begin
								rem_d   = rem_q | {16'd0, in_byte, 8'd0};
								phase_d = lzsw_pkg::PH_HDR2;
							end
							lzsw_pkg::PH_HDR2: begin
								rem_d   = rem_q | {8'd0, in_byte, 16'd0};
								phase_d = lzsw_pkg::PH_HDR3;
							end
							lzsw_pkg::PH_HDR3: begin
								rem_d   = rem_q | {in_byte, 24'd0};
								phase_d = (rem_d == 32'd0) ? lzsw_pkg::PH_DONE
								                           : lzsw_pkg::PH_ITEM;
							end
							lzsw_pkg::PH_ITEM: begin
								if (flag_q[8:1] == 8'd0) begin
									flag_d = {1'b1, in_byte};
								end else begin
									flag_d = {1'b0, flag_q[8:1]};
									if (flag_q[0]) begin
										lit_d   = in_byte;
										state_d = lzsw_pkg::ST_LIT;
									end else begin
										mlow_d  = in_byte;
										phase_d = lzsw_pkg::PH_MATCH;
									end
								end
							end
							lzsw_pkg::PH_MATCH: begin
								rd_ptr_d  = {in_byte[7:4], mlow_q};
								rd_left_d = {1'b0, in_byte[3:0]} + lzsw_pkg::MIN_MATCH;
								em_left_d = {1'b0, in_byte[3:0]} + lzsw_pkg::MIN_MATCH;
								dv_d      = 1'b0;
								phase_d   = lzsw_pkg::PH_ITEM;
								state_d   = lzsw_pkg::ST_COPY;
							end
							default: begin
							end
						endcase
					end
				end
			end
			lzsw_pkg::ST_LIT: begin
				if (out_free) begin
					put_en   = 1'b1;
					put_byte = lit_q;
					state_d  = lzsw_pkg::ST_IDLE;
				end
			end
			lzsw_pkg::ST_COPY: begin
				if (dv_q && out_free) begin
					put_en       = 1'b1;
					put_byte     = copy_byte;
					put_run_last = (em_left_q == 5'd1) || fin;
					em_left_d    = em_left_q - 5'd1;
					dv_d         = 1'b0;
					if (put_run_last) begin
						state_d = lzsw_pkg::ST_IDLE;
					end
				end
				if ((rd_left_q != 5'd0) && (!dv_q || out_free)) begin
					ram_req.re = 1'b1;
					ram_req.raddr = rd_ptr_q;
					rd_ptr_d   = rd_ptr_q + 1'b1;
					rd_left_d  = rd_left_q - 5'd1;
					dv_d       = 1'b1;
					byp_d      = put_en && (rd_ptr_q == wp_q);
					byp_data_d = copy_byte;
				end
			end
			default: begin
				state_d = lzsw_pkg::ST_IDLE;
			end
		endcase

		// one output byte: window write, count down, present at the output
		if (put_en) begin
			ram_req.we     = 1'b1;
			ram_req.waddr  = wp_q;
			ram_req.wdata  = put_byte;
			wp_d           = wp_q + 1'b1;
			rem_d          = rem_dec;
			ob.load        = 1'b1;
			ob.data        = put_byte;
			ob.run_last    = put_run_last;
			ob.stream_last = fin;
			if (fin) begin
				phase_d = lzsw_pkg::PH_DONE;
			end
		end
	end

endmodule
